>>> rtl/aes_pkg.sv
package aes_pkg;

    localparam logic [1:0] MODE_LOAD = 2'd0;
    localparam logic [1:0] MODE_ENC  = 2'd1;
    localparam logic [1:0] MODE_DEC  = 2'd2;

    typedef logic [127:0] block_t;

    function automatic logic [7:0] xtime(input logic [7:0] v);
        return {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] acc;
        logic [7:0] x;
        acc = 8'h00;
        x = a;
        for (int i = 0; i < 8; i++) begin
            if (b[i]) begin
                acc = acc ^ x;
            end
            x = xtime(x);
        end
        return acc;
    endfunction

    function automatic logic [7:0] gf_inv(input logic [7:0] a);
        logic [7:0] r;
        logic [7:0] base;
        r = 8'h01;
        base = a;
        for (int i = 0; i < 8; i++) begin
            if (i != 0) begin
                r = gf_mul(r, base);
            end
            base = gf_mul(base, base);
        end
        return r;
    endfunction

    function automatic logic [7:0] rotl8(input logic [7:0] v, input int n);
        return 8'((v << n) | (v >> (8 - n)));
    endfunction

    function automatic logic [7:0] sbox(input logic [7:0] v);
        logic [7:0] q;
        q = gf_inv(v);
        return q ^ rotl8(q, 1) ^ rotl8(q, 2) ^ rotl8(q, 3) ^ rotl8(q, 4) ^ 8'h63;
    endfunction

    function automatic logic [7:0] inv_sbox(input logic [7:0] v);
        return gf_inv(rotl8(v, 1) ^ rotl8(v, 3) ^ rotl8(v, 6) ^ 8'h05);
    endfunction

    typedef logic [7:0] sbox_tab_t [256];

    function automatic sbox_tab_t make_sbox(input logic inverse);
        sbox_tab_t t;
        for (int i = 0; i < 256; i++) begin
            t[i] = inverse ? inv_sbox(8'(i)) : sbox(8'(i));
        end
        return t;
    endfunction

    localparam sbox_tab_t SBOX_FWD = make_sbox(1'b0);
    localparam sbox_tab_t SBOX_INV = make_sbox(1'b1);

    // byte i of the block sits at bits 127-8*i
    function automatic logic [7:0] get_byte(input block_t b, input int i);
        return b[127 - 8 * i -: 8];
    endfunction

endpackage

>>> rtl/aes_ram.sv
module aes_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 60
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> rtl/aes_round.sv
module aes_round (
    input  aes_pkg::block_t state_in,
    input  logic            inverse,
    input  logic            last,
    output aes_pkg::block_t state_out
);
    import aes_pkg::*;

    block_t sh;
    block_t sb;
    block_t mx;

    always_comb begin
        logic [7:0] c [4];
        for (int col = 0; col < 4; col++) begin
            for (int r = 0; r < 4; r++) begin
                sh[127 - 8 * (4 * col + r) -: 8] = inverse ?
                    get_byte(state_in, 4 * ((col + 4 - r) % 4) + r) :
                    get_byte(state_in, 4 * ((col + r) % 4) + r);
            end
        end
        for (int i = 0; i < 16; i++) begin
            sb[127 - 8 * i -: 8] = inverse ? SBOX_INV[get_byte(sh, i)] :
                                             SBOX_FWD[get_byte(sh, i)];
        end
        for (int col = 0; col < 4; col++) begin
            for (int r = 0; r < 4; r++) begin
                c[r] = get_byte(sb, 4 * col + r);
            end
            for (int r = 0; r < 4; r++) begin
                if (inverse) begin
                    mx[127 - 8 * (4 * col + r) -: 8] =
                        gf_mul(8'h0e, c[r]) ^ gf_mul(8'h0b, c[(r + 1) % 4]) ^
                        gf_mul(8'h0d, c[(r + 2) % 4]) ^ gf_mul(8'h09, c[(r + 3) % 4]);
                end else begin
                    mx[127 - 8 * (4 * col + r) -: 8] =
                        xtime(c[r]) ^ xtime(c[(r + 1) % 4]) ^ c[(r + 1) % 4] ^
                        c[(r + 2) % 4] ^ c[(r + 3) % 4];
                end
            end
        end
    end

    // inverse rounds take the mix after the key add: handled by the caller
    assign state_out = (last || inverse) ? sb : mx;

endmodule

>>> rtl/aes_block_encrypt_decrypt.sv
// AES block cipher over an externally loaded key schedule (60 words of 32 bits).
// Mode 0 beats write one schedule word each. In an encrypt or decrypt beat
// the four words of each round key are read as one 128-bit row of the key
// RAM, one row a cycle, and one shared round unit does one round per cycle.
// A bad round count returns zero with status 1. The result sits in an output
// register; the next beat is taken once that register has been handed over.
module aes_block_encrypt_decrypt #(
    parameter int MAX_ROUNDS = 14
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          cfg_we,
    input  logic [3:0]    cfg_wdata,
    input  logic          s_valid,
    output logic          s_ready,
    input  logic [1:0]    s_mode,
    input  logic [5:0]    s_word_index,
    input  logic [31:0]   s_key_word,
    input  logic [63:0]   s_data_high,
    input  logic [63:0]   s_data_low,
    output logic          m_valid,
    input  logic          m_ready,
    output logic [63:0]   m_result_high,
    output logic [63:0]   m_result_low,
    output logic          m_status
);
    import aes_pkg::*;

    localparam int ROWS = MAX_ROUNDS + 1;
    localparam int RW = $clog2(ROWS);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_ERR  = 2'd2;

    logic [3:0]   nr_reg;
    logic [1:0]   st_reg, st_next;
    logic         inv_reg;
    logic [3:0]   cnt_reg, cnt_next;
    logic         first_reg;
    block_t       blk_reg, blk_next;
    logic         mv_reg;
    block_t       res_reg;
    logic         stat_reg;

    logic         acc, nr_ok, load_ok;
    logic [RW-1:0] raddr;
    logic [3:0]   kw_we;
    logic [127:0] rkey;
    block_t       rnd_out, keyed, mixed;
    logic         last;

    assign acc = s_valid && s_ready;
    assign s_ready = (st_reg == ST_IDLE) && !mv_reg;
    assign nr_ok = (nr_reg == 4'd10 || nr_reg == 4'd12 || nr_reg == 4'd14) &&
                   (32'(nr_reg) <= MAX_ROUNDS);
    assign load_ok = 32'(s_word_index) < 4 * ROWS;

    for (genvar g = 0; g < 4; g++) begin : g_bank
        assign kw_we[g] = acc && s_mode == MODE_LOAD && load_ok &&
                          s_word_index[1:0] == 2'(g);
        aes_ram #(.WIDTH(32), .DEPTH(ROWS)) u_ram (
            .aclk  (aclk),
            .we    (kw_we[g]),
            .waddr (RW'(s_word_index[5:2])),
            .wdata (s_key_word),
            .raddr (raddr),
            .rdata (rkey[127 - 32 * g -: 32])
        );
    end

    // row read this cycle: round key for the step after cnt
    always_comb begin
        logic [3:0] r;
        if (st_reg == ST_IDLE) begin
            r = (s_mode == MODE_DEC) ? nr_reg : 4'd0;
        end else if (inv_reg) begin
            r = nr_reg - cnt_reg - 4'd1;
        end else begin
            r = cnt_reg + 4'd1;
        end
        raddr = RW'(r);
    end

    assign last = (cnt_reg == nr_reg);

    aes_round u_round (
        .state_in  (blk_reg),
        .inverse   (inv_reg),
        .last      (last),
        .state_out (rnd_out)
    );

    assign keyed = (first_reg ? blk_reg : rnd_out) ^ rkey;

    always_comb begin
        logic [7:0] c [4];
        for (int col = 0; col < 4; col++) begin
            for (int r = 0; r < 4; r++) begin
                c[r] = get_byte(keyed, 4 * col + r);
            end
            for (int r = 0; r < 4; r++) begin
                mixed[127 - 8 * (4 * col + r) -: 8] =
                    gf_mul(8'h0e, c[r]) ^ gf_mul(8'h0b, c[(r + 1) % 4]) ^
                    gf_mul(8'h0d, c[(r + 2) % 4]) ^ gf_mul(8'h09, c[(r + 3) % 4]);
            end
        end
    end

    always_comb begin
        st_next = st_reg;
        cnt_next = cnt_reg;
        blk_next = blk_reg;
        case (st_reg)
            ST_IDLE: begin
                if (acc && (s_mode == MODE_ENC || s_mode == MODE_DEC)) begin
                    st_next = nr_ok ? ST_RUN : ST_ERR;
                    cnt_next = 4'd0;
                    blk_next = {s_data_high, s_data_low};
                end
            end
            ST_RUN: begin
                blk_next = (inv_reg && !first_reg && !last) ? mixed : keyed;
                if (first_reg) begin
                    blk_next = keyed;
                end
                cnt_next = cnt_reg + 4'd1;
                if (!first_reg && last) begin
                    st_next = ST_IDLE;
                end
            end
            ST_ERR: st_next = ST_IDLE;
            default: st_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= ST_IDLE;
            nr_reg <= 4'd10;
            mv_reg <= 1'b0;
            cnt_reg <= 4'd0;
            first_reg <= 1'b0;
            inv_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                nr_reg <= cfg_wdata;
            end
            st_reg <= st_next;
            cnt_reg <= cnt_next;
            if (st_reg == ST_IDLE && acc) begin
                inv_reg <= (s_mode == MODE_DEC);
                first_reg <= 1'b1;
            end else if (st_reg == ST_RUN) begin
                first_reg <= 1'b0;
            end
            if (m_valid && m_ready) begin
                mv_reg <= 1'b0;
            end
            if ((st_reg == ST_RUN && !first_reg && last) || st_reg == ST_ERR) begin
                mv_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        blk_reg <= blk_next;
        if (st_reg == ST_ERR) begin
            res_reg <= '0;
            stat_reg <= 1'b1;
        end else if (st_reg == ST_RUN && !first_reg && last) begin
            res_reg <= keyed;
            stat_reg <= 1'b0;
        end
    end

    assign m_valid = mv_reg;
    assign m_result_high = res_reg[127:64];
    assign m_result_low = res_reg[63:0];
    assign m_status = stat_reg;

    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        st_reg != ST_IDLE |-> !s_ready) else $error("accept while busy");
    a_done_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        (st_reg == ST_ERR) |=> m_valid && m_status) else $error("error result lost");
    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        st_reg == ST_RUN |-> cnt_reg <= nr_reg) else $error("round counter overrun");

endmodule
